// ===== hw/rtl/boosted_lattice_minkowski_cell_test_assert.svh =====
// Assertion macros shared by the cell test RTL.
// Every macro expects clk_i and rst_ni in the scope where it is used.
`ifndef BOOSTED_LATTICE_MINKOWSKI_CELL_TEST_ASSERT_SVH
`define BOOSTED_LATTICE_MINKOWSKI_CELL_TEST_ASSERT_SVH

// A property that must hold at every clock edge out of reset.
`define BLMC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A condition that must never be seen out of reset.
`define BLMC_NEVER(name, cond, msg) \
  `BLMC_ASSERT(name, !(cond), msg)

`endif

// ===== hw/rtl/blmc_pkg.sv =====
// Shared widths, constants, register codes and the job word of the cell test.
// No dependencies; the front, the back and the top level import it.
`default_nettype none

package blmc_pkg;

  localparam int PixW      = 8;
  localparam int ScaleW    = 18;
  localparam int ScaleInvW = 17;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 18;

  // Datapath widths, sized for the largest image and lattice range.
  localparam int FracW   = 16;
  localparam int DvdW    = 30;
  localparam int CentreW = 24;
  localparam int SumW    = 25;
  localparam int DepthW  = 48;
  localparam int PtW     = 26;
  localparam int ScW     = 44;
  localparam int BiasW   = 46;
  localparam int AbW     = 29;
  localparam int ProdW   = 58;

  localparam int Sqrt3Q16  = 113512;
  localparam int HalfQ16   = 32768;
  localparam int CentreMul = 196608;

  typedef logic [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;

  localparam cfg_idx_t RegBoostScale    = 2'd0;
  localparam cfg_idx_t RegBoostScaleInv = 2'd1;

  // One classified pixel handed from the front to the back.
  typedef struct packed {
    logic signed [SumW-1:0] sum;
    logic signed [SumW-1:0] diff;
    logic [DepthW-1:0]      depth;
  } job_t;

endpackage

`default_nettype wire

// ===== hw/rtl/blmc_queue.sv =====
// Small register queue used between the front and the back and at the result side.
// Depends only on the assertion header.
`default_nettype none
`include "boosted_lattice_minkowski_cell_test_assert.svh"

module blmc_queue #(
  parameter int Width = 1,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  `BLMC_ASSERT(a_count_bound, count_q <= CntW'(Depth), "queue count above depth")
  `BLMC_ASSERT(a_ptr_gap, PtrW'(wr_ptr_q - rd_ptr_q) == count_q[PtrW-1:0], "queue pointers disagree with count")

endmodule

`default_nettype wire

// ===== hw/rtl/blmc_front.sv =====
// Front part: takes a pixel, finds its plane point by reciprocal multiplication and its depth.
// Depends on blmc_pkg; hands a job word to the job queue.
`default_nettype none
`include "boosted_lattice_minkowski_cell_test_assert.svh"

module blmc_front #(
  parameter int IMAGE_SIZE = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  output logic                      full_o,
  input  logic [blmc_pkg::PixW-1:0] pixel_x_i,
  input  logic [blmc_pkg::PixW-1:0] pixel_y_i,
  output logic                      job_push_o,
  input  logic                      job_full_i,
  output blmc_pkg::job_t            job_o
);

  import blmc_pkg::*;

  localparam int Divisor  = 2 * IMAGE_SIZE;
  localparam int RecShift = DvdW + $clog2(Divisor);
  localparam int QProdW   = 2 * DvdW + 1;
  // Reciprocal rounded up; the shifted product is the exact floor for any dividend
  // below 2^DvdW.
  localparam logic [DvdW:0]         Recip    =
      (DvdW + 1)'(((64'd1 << RecShift) + 64'(Divisor) - 64'd1) / 64'(Divisor));
  localparam logic signed [31:0]    PixMul   = 32'(2 * CentreMul);
  localparam logic signed [31:0]    MOfs     = 32'(CentreMul * (1 - IMAGE_SIZE) + IMAGE_SIZE);
  localparam logic signed [31:0]    NegOfs   = 32'(Divisor - 1);

  typedef enum logic [7:0] {
    F_IDLE = 8'b0000_0001,
    F_PREP = 8'b0000_0010,
    F_DIV  = 8'b0000_0100,
    F_FIX  = 8'b0000_1000,
    F_SUM  = 8'b0001_0000,
    F_MUL  = 8'b0010_0000,
    F_ABS  = 8'b0100_0000,
    F_PUSH = 8'b1000_0000
  } front_state_e;

  front_state_e state_q, state_d;

  // Two lanes, one for each coordinate.
  logic [PixW-1:0]           pix_q  [2];
  logic [DvdW-1:0]           dq_q   [2];
  logic                      neg_q  [2];
  logic signed [CentreW-1:0] ctr_q  [2];
  logic signed [31:0]        num    [2];
  logic signed [31:0]        mag    [2];
  logic [QProdW-1:0]         qprod  [2];

  logic signed [SumW-1:0]     sum_q, diff_q;
  logic signed [2*SumW-1:0]   prod_q;
  logic [DepthW-1:0]          depth_q;
  logic                       accept;

  assign full_o     = !(state_q == F_IDLE || (state_q == F_PUSH && !job_full_i));
  assign accept     = push_i && !full_o;
  assign job_push_o = (state_q == F_PUSH) && !job_full_i;

  always_comb begin
    job_o.sum   = sum_q;
    job_o.diff  = diff_q;
    job_o.depth = depth_q;
  end

  // The numerator is shifted so that a negative value divides with floor.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      num[i]   = $signed(32'(pix_q[i])) * PixMul + MOfs;
      mag[i]   = num[i][31] ? (NegOfs - num[i]) : num[i];
      qprod[i] = QProdW'(dq_q[i]) * QProdW'(Recip);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: if (accept) state_d = F_PREP;
      F_PREP: state_d = F_DIV;
      F_DIV:  state_d = F_FIX;
      F_FIX:  state_d = F_SUM;
      F_SUM:  state_d = F_MUL;
      F_MUL:  state_d = F_ABS;
      F_ABS:  state_d = F_PUSH;
      F_PUSH: begin
        if (!job_full_i) state_d = accept ? F_PREP : F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q[0] <= pixel_x_i;
      pix_q[1] <= pixel_y_i;
    end
    for (int i = 0; i < 2; i++) begin
      if (state_q == F_PREP) begin
        dq_q[i]  <= mag[i][DvdW-1:0];
        neg_q[i] <= num[i][31];
      end else if (state_q == F_DIV) begin
        dq_q[i]  <= DvdW'(qprod[i] >> RecShift);
      end
      if (state_q == F_FIX) begin
        ctr_q[i] <= neg_q[i] ? -$signed(dq_q[i][CentreW-1:0])
                             : $signed(dq_q[i][CentreW-1:0]);
      end
    end
    if (state_q == F_SUM) begin
      sum_q  <= SumW'(ctr_q[0]) + SumW'(ctr_q[1]);
      diff_q <= SumW'(ctr_q[0]) - SumW'(ctr_q[1]);
    end
    if (state_q == F_MUL) begin
      prod_q <= (2 * SumW)'(sum_q) * (2 * SumW)'(diff_q);
    end
    if (state_q == F_ABS) begin
      depth_q <= DepthW'(prod_q[2*SumW-1] ? -prod_q : prod_q);
    end
  end

  `BLMC_ASSERT(a_job_held, (state_q == F_PUSH && job_full_i) |=> (state_q == F_PUSH && $stable(depth_q)), "front dropped a waiting job")

endmodule

`default_nettype wire

// ===== hw/rtl/blmc_back.sv =====
// Back part: sweeps the lattice for one job, one point per cycle through a pipeline.
// Depends on blmc_pkg; reads the job queue and writes the result queue.
`default_nettype none
`include "boosted_lattice_minkowski_cell_test_assert.svh"

module blmc_back #(
  parameter int LATTICE_RANGE = 40
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [blmc_pkg::ScaleW-1:0]    scale_i,
  input  logic [blmc_pkg::ScaleInvW-1:0] scale_inv_i,
  input  blmc_pkg::job_t                 job_i,
  input  logic                           job_empty_i,
  output logic                           job_pop_o,
  output logic                           out_push_o,
  input  logic                           out_full_i,
  output logic                           hit_o
);

  import blmc_pkg::*;

  localparam int CntW = $clog2(LATTICE_RANGE + 1) + 1;
  localparam int PipeN = 4;
  localparam logic signed [CntW-1:0] RPos   = CntW'(LATTICE_RANGE);
  localparam logic signed [CntW-1:0] RNeg   = -RPos;
  localparam logic signed [PtW-1:0]  Sqrt3W = PtW'(Sqrt3Q16);
  localparam logic signed [BiasW-1:0] HalfW = BiasW'(HalfQ16);

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_RUN   = 4'b0010,
    B_DRAIN = 4'b0100,
    B_DONE  = 4'b1000
  } back_state_e;

  back_state_e state_q, state_d;
  logic signed [CntW-1:0] gx_q, gx_d, gy_q, gy_d;
  logic [PipeN-1:0]       pv_q;
  logic                   issue, load, hit_q, closer;

  // Per-job constants: rounding bias folded with the centre, and the depth window.
  logic signed [BiasW-1:0] bias_a_q, bias_b_q;
  logic signed [ProdW-1:0] dpos_q, dneg_q, dpos_d;

  logic signed [PtW-1:0]   gx_w, gy_w, plus_d, minus_d, plus_q, minus_q;
  logic signed [ScW-1:0]   ps_q, ms_q;
  logic signed [BiasW-1:0] sa, sb;
  logic signed [AbW-1:0]   a_q, b_q;
  logic signed [ProdW-1:0] ab_q;
  logic signed [ScW-1:0]   sc_w, si_w;

  assign gx_w    = PtW'(gx_q);
  assign gy_w    = PtW'(gy_q);
  assign plus_d  = (gx_w <<< FracW) + gy_w * Sqrt3W;
  assign minus_d = (gx_w <<< FracW) - gy_w * Sqrt3W;
  assign sc_w    = ScW'($signed({1'b0, scale_i}));
  assign si_w    = ScW'($signed({1'b0, scale_inv_i}));
  assign sa      = BiasW'(ps_q) + bias_a_q;
  assign sb      = BiasW'(ms_q) + bias_b_q;
  assign dpos_d  = $signed(ProdW'(job_i.depth));
  assign closer  = (ab_q < dpos_q) && (ab_q > dneg_q);
  assign hit_o   = hit_q;

  always_comb begin
    state_d    = state_q;
    gx_d       = gx_q;
    gy_d       = gy_q;
    job_pop_o  = 1'b0;
    out_push_o = 1'b0;
    issue      = 1'b0;
    load       = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          load      = 1'b1;
          gx_d      = RNeg;
          gy_d      = RNeg;
          state_d   = B_RUN;
        end
      end
      B_RUN: begin
        // The origin is stepped over without a test.
        issue = !(gx_q == '0 && gy_q == '0);
        if (gy_q == RPos) begin
          gy_d = RNeg;
          if (gx_q == RPos) begin
            state_d = B_DRAIN;
          end else begin
            gx_d = gx_q + CntW'(1);
          end
        end else begin
          gy_d = gy_q + CntW'(1);
        end
      end
      B_DRAIN: if (pv_q == '0) state_d = B_DONE;
      B_DONE: begin
        if (!out_full_i) begin
          out_push_o = 1'b1;
          state_d    = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      gx_q    <= '0;
      gy_q    <= '0;
      pv_q    <= '0;
      hit_q   <= 1'b1;
    end else begin
      state_q <= state_d;
      gx_q    <= gx_d;
      gy_q    <= gy_d;
      pv_q    <= {pv_q[PipeN-2:0], issue};
      if (load) begin
        hit_q <= 1'b1;
      end else if (pv_q[PipeN-1] && closer) begin
        hit_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bias_a_q <= HalfW - (BiasW'(job_i.sum) <<< FracW);
      bias_b_q <= HalfW - (BiasW'(job_i.diff) <<< FracW);
      dpos_q   <= dpos_d;
      dneg_q   <= -dpos_d;
    end
    plus_q  <= plus_d;
    minus_q <= minus_d;
    ps_q    <= sc_w * ScW'(plus_q);
    ms_q    <= si_w * ScW'(minus_q);
    a_q     <= sa[FracW +: AbW];
    b_q     <= sb[FracW +: AbW];
    ab_q    <= ProdW'(a_q) * ProdW'(b_q);
  end

  `BLMC_ASSERT(a_push_drained, out_push_o |-> (pv_q == '0), "result sent with points still in flight")
  `BLMC_ASSERT(a_pop_starts, job_pop_o |=> (state_q == B_RUN && gx_q == RNeg && gy_q == RNeg), "sweep did not start at the corner")

endmodule

`default_nettype wire

// ===== hw/rtl/boosted_lattice_minkowski_cell_test.sv =====
// Top level of the boosted lattice Minkowski cell test: configuration registers,
// front, job queue, back and result queue. Depends on blmc_pkg and the blmc_* modules.
//
//   channel   direction  handshake               payload
//   input     in         push / full             pixel_x_i, pixel_y_i
//   result    out        empty / pop             hit_o
//   config    in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// The back sweeps the lattice one point per cycle, and that sweep sets the sustained rate.
// The front works on the next word meanwhile.
// Reset is asynchronous and active low; both registers come out of it at 1.0.
// A full result queue stalls the back, and a full job queue then stalls the front.
`default_nettype none

module boosted_lattice_minkowski_cell_test #(
  parameter int IMAGE_SIZE    = 256,
  parameter int LATTICE_RANGE = 40
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [blmc_pkg::PixW-1:0] pixel_x_i,
  input  logic [blmc_pkg::PixW-1:0] pixel_y_i,
  output logic                      empty,
  input  logic                      pop,
  output logic                      hit_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  blmc_pkg::cfg_idx_t        cfg_index_i,
  input  blmc_pkg::cfg_data_t       cfg_data_i
);

  import blmc_pkg::*;

  localparam int JobW = $bits(job_t);

  logic [ScaleW-1:0]    scale_q, scale_d;
  logic [ScaleInvW-1:0] scale_inv_q, scale_inv_d;

  job_t            front_job, back_job;
  logic [JobW-1:0] job_wr, job_rd;
  logic            job_push, job_full, job_pop, job_empty;
  logic            out_push, out_full, back_hit;

  assign cfg_ready_o = 1'b1;
  assign job_wr      = front_job;
  assign back_job    = job_rd;

  always_comb begin
    scale_d     = scale_q;
    scale_inv_d = scale_inv_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegBoostScale:    scale_d     = cfg_data_i[ScaleW-1:0];
        RegBoostScaleInv: scale_inv_d = cfg_data_i[ScaleInvW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q     <= ScaleW'(1 << FracW);
      scale_inv_q <= ScaleInvW'(1 << FracW);
    end else begin
      scale_q     <= scale_d;
      scale_inv_q <= scale_inv_d;
    end
  end

  blmc_front #(
    .IMAGE_SIZE (IMAGE_SIZE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .pixel_x_i  (pixel_x_i),
    .pixel_y_i  (pixel_y_i),
    .job_push_o (job_push),
    .job_full_i (job_full),
    .job_o      (front_job)
  );

  blmc_queue #(
    .Width (JobW),
    .Depth (2)
  ) u_job_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_wr),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_rd),
    .empty_o (job_empty)
  );

  blmc_back #(
    .LATTICE_RANGE (LATTICE_RANGE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scale_i     (scale_q),
    .scale_inv_i (scale_inv_q),
    .job_i       (back_job),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .out_push_o  (out_push),
    .out_full_i  (out_full),
    .hit_o       (back_hit)
  );

  blmc_queue #(
    .Width (1),
    .Depth (2)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (back_hit),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (hit_o),
    .empty_o (empty)
  );

endmodule

`default_nettype wire

// ===== sim/tb_boosted_lattice_minkowski_cell_test.sv =====
// Testbench for the boosted lattice Minkowski cell test: queue-style pixel and result ports,
// register writes between phases, and a self-contained predictor of the hit bit.
// Depends on blmc_pkg and the boosted_lattice_minkowski_cell_test RTL.
`timescale 1ns / 100ps

module tb_boosted_lattice_minkowski_cell_test;
  import blmc_pkg::*;

  localparam int ImageSize     = 256;
  localparam int LatticeRange  = 40;
  localparam int OneQ16        = 65536;
  localparam int SweepCycles   = (2 * LatticeRange + 1) * (2 * LatticeRange + 1) + 64;
  localparam int HoldCap       = 16 * SweepCycles;
  localparam int TimeoutCycles = 4_000_000;

  // Indexes that decode to no register; writes to them must be ignored.
  localparam cfg_idx_t RegSpareLow  = 2'd2;
  localparam cfg_idx_t RegSpareHigh = 2'd3;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic [PixW-1:0]   pixel_x_i = '0;
  logic [PixW-1:0]   pixel_y_i = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic              hit_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  cfg_idx_t          cfg_index_i = RegBoostScale;
  cfg_data_t         cfg_data_i = '0;

  // Register shadow used by the predictor.
  longint            boost_q16 = OneQ16;
  longint            boost_inv_q16 = OneQ16;

  logic              expected_hits[$];
  logic              want_hit;
  int                gap_pct = 0;
  int                stall_pct = 0;
  logic              hold_pop = 1'b0;
  int                fails = 0;
  int                pixels_sent = 0;
  int                hits_seen = 0;
  int                settings_used = 0;
  int                full_cycles = 0;

  boosted_lattice_minkowski_cell_test #(
    .IMAGE_SIZE   (ImageSize),
    .LATTICE_RANGE(LatticeRange)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .pixel_x_i  (pixel_x_i),
    .pixel_y_i  (pixel_y_i),
    .empty      (empty),
    .pop        (pop),
    .hit_o      (hit_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (TimeoutCycles) @(posedge clk_i);
    $error("timeout with %0d results still expected", expected_hits.size());
    $display("== FAIL ==");
    $finish;
  end

  // Pixel centre in Q16, rounded to nearest with ties upward.
  function automatic longint pixel_centre(input logic [PixW-1:0] p);
    longint num;
    longint den;
    num = longint'(CentreMul) * (2 * longint'(p) - ImageSize + 1) + ImageSize;
    den = 2 * ImageSize;
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  // A pixel is a hit unless some boosted lattice point lies strictly shallower.
  function automatic logic cell_hit(input logic [PixW-1:0] x, input logic [PixW-1:0] y);
    longint ex, ey, sum, diff, depth, plus, minus, a, b, prod;
    int gx, gy;
    ex = pixel_centre(x);
    ey = pixel_centre(y);
    sum = ex + ey;
    diff = ex - ey;
    depth = sum * diff;
    if (depth < 0) depth = -depth;
    for (gx = -LatticeRange; gx <= LatticeRange; gx++) begin
      for (gy = -LatticeRange; gy <= LatticeRange; gy++) begin
        if (gx == 0 && gy == 0) continue;
        plus = longint'(gx) * OneQ16 + longint'(gy) * Sqrt3Q16;
        minus = longint'(gx) * OneQ16 - longint'(gy) * Sqrt3Q16;
        a = ((boost_q16 * plus + HalfQ16) >>> FracW) - sum;
        b = ((boost_inv_q16 * minus + HalfQ16) >>> FracW) - diff;
        prod = a * b;
        if (prod < 0) prod = -prod;
        if (prod < depth) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Result side: check every popped word, then choose pop for the next cycle.
  always @(posedge clk_i) begin
    if (push && full) full_cycles++;
    if (pop && !empty) begin
      if (expected_hits.size() == 0) begin
        $error("hit word with no expectation waiting: actual %0b", hit_o);
        fails++;
      end else begin
        want_hit = expected_hits.pop_front();
        if (hit_o !== want_hit) begin
          $error("hit mismatch: expected %0b actual %0b", want_hit, hit_o);
          fails++;
        end
        if (want_hit) hits_seen++;
      end
    end
    pop <= rst_ni && !hold_pop && ($urandom_range(99) >= stall_pct);
  end

  task automatic send_pixel(input logic [PixW-1:0] x, input logic [PixW-1:0] y);
    push <= 1'b1;
    pixel_x_i <= x;
    pixel_y_i <= y;
    do @(posedge clk_i); while (full !== 1'b0);
    expected_hits.push_back(cell_hit(x, y));
    pixels_sent++;
    // Random gap before the next word; a run of zero gaps keeps push high.
    if ($urandom_range(99) < gap_pct) begin
      push <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
  endtask

  task automatic write_register(input cfg_idx_t idx, input cfg_data_t data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegBoostScale:    boost_q16 = longint'(data[ScaleW-1:0]);
      RegBoostScaleInv: boost_inv_q16 = longint'(data[ScaleInvW-1:0]);
      default: ;
    endcase
  endtask

  // Stop sending and let every outstanding word come back.
  task automatic settle();
    push <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_boost(input cfg_data_t scale, input cfg_data_t scale_inv);
    write_register(RegBoostScale, scale);
    write_register(RegBoostScaleInv, scale_inv);
    settings_used++;
  endtask

  task automatic test_directed_pixels();
    gap_pct = 0;
    stall_pct = 0;
    settings_used++;
    // Corners and image centre sit on the light cones, so they must hit.
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd255, 8'd255);
    send_pixel(8'd0, 8'd255);
    send_pixel(8'd255, 8'd0);
    send_pixel(8'd127, 8'd128);
    send_pixel(8'd128, 8'd128);
    send_pixel(8'd0, 8'd128);
    send_pixel(8'd255, 8'd127);
    send_pixel(8'd128, 8'd0);
    send_pixel(8'd127, 8'd255);
    send_pixel(8'd130, 8'd127);
    send_pixel(8'd127, 8'd140);
    send_pixel(8'd160, 8'd100);
    send_pixel(8'd64, 8'd200);
    send_pixel(8'd200, 8'd64);
    settle();
  endtask

  task automatic test_register_extremes();
    set_boost(18'd262143, 18'd16384);
    send_pixel(8'd128, 8'd131);
    send_pixel(8'd40, 8'd90);
    settle();
    set_boost(18'd0, 18'd0);
    send_pixel(8'd130, 8'd127);
    send_pixel(8'd0, 8'd128);
    settle();
    // The top data bit falls outside the inverse register and is dropped.
    set_boost(18'd262143, 18'h3FFFF);
    send_pixel(8'd160, 8'd100);
    send_pixel(8'd250, 8'd3);
    settle();
    set_boost(18'd65536, 18'd65536);
    write_register(RegSpareLow, 18'd0);
    write_register(RegSpareHigh, 18'h3FFFF);
    send_pixel(8'd128, 8'd131);
    send_pixel(8'd100, 8'd170);
    settle();
  endtask

  // Keep pop low until the input has been held off for a while, so every queue fills.
  task automatic test_full_backpressure();
    int held;
    int full_run;
    int k;
    gap_pct = 0;
    stall_pct = 0;
    hold_pop = 1'b1;
    fork
      begin
        held = 0;
        full_run = 0;
        while (held < HoldCap && full_run < 2 * SweepCycles) begin
          @(posedge clk_i);
          held++;
          full_run = full ? full_run + 1 : 0;
        end
        hold_pop = 1'b0;
      end
      begin
        for (k = 0; k < 12; k++) begin
          send_pixel(PixW'($urandom_range(255)), PixW'($urandom_range(255)));
        end
        push <= 1'b0;
        @(posedge clk_i);
      end
    join
    settle();
  endtask

  task automatic test_random_pixels(input int count, input int idle, input int stall,
                                    input cfg_data_t scale, input cfg_data_t scale_inv);
    int k;
    int pick;
    logic [PixW-1:0] x;
    logic [PixW-1:0] y;
    set_boost(scale, scale_inv);
    gap_pct = idle;
    stall_pct = stall;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(5);
      x = PixW'($urandom_range(255));
      if (pick == 0) begin
        y = $urandom_range(1) ? x : 8'd255 - x;
      end else if (pick <= 2) begin
        // Near the centre the cells are large enough for hits to be common.
        x = PixW'($urandom_range(96, 159));
        y = PixW'($urandom_range(96, 159));
      end else begin
        y = PixW'($urandom_range(255));
      end
      send_pixel(x, y);
    end
    settle();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    test_directed_pixels();
    test_register_extremes();
    test_full_backpressure();
    test_random_pixels(20, 0, 0, 18'd65536, 18'd65536);
    test_random_pixels(20, 79, 0, 18'd262143, 18'd16384);
    test_random_pixels(20, 0, 79, 18'd131072, 18'd32768);
    test_random_pixels(20, 35, 35, cfg_data_t'($urandom_range(65536, 262143)),
                       cfg_data_t'($urandom_range(16384, 65536)));

    gap_pct = 0;
    stall_pct = 0;
    // One full sweep more, so a stray word would still show up.
    repeat (SweepCycles) @(posedge clk_i);
    if (expected_hits.size() != 0) begin
      $error("%0d hit words never arrived", expected_hits.size());
      fails++;
    end
    $display("Summary: %0d pixels over %0d boost settings, %0d hits, input held off %0d cycles",
             pixels_sent, settings_used, hits_seen, full_cycles);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
